>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file sflm_checker.sv.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

>>> hw/rtl/sflm_pkg.sv
// Types and constants for the substring first/last match block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package sflm_pkg;

  localparam int MaxPatternDef = 16;
  localparam int MaxTextDef    = 65536;
  localparam int RegW          = 64;
  localparam int LenW          = 5;
  localparam int CfgIdxW       = 2;
  localparam int PatBytes      = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatLo  = 2'd0,
    CfgPatHi  = 2'd1,
    CfgPatLen = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PatBytes-1:0][7:0] pattern;
    logic [LenW-1:0]          length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [15:0] first_start;
    logic [15:0] last_start;
    logic        length_overflow;
  } out_t;

  typedef struct packed {
    logic       shift;
    logic [7:0] data;
  } win_ctl_t;

endpackage

>>> hw/rtl/substring_first_last_match.sv
// Top level: input register, window compare, occurrence tracking, result register.
// Depends on sflm_pkg, sflm_cfg and sflm_window.
//
//   port group   direction  handshake          payload
//   cfg          in         cfg_we_i           cfg_idx_i, cfg_wdata_i
//   in           in         in_valid/in_ready  in_data_i (text_byte, text_end)
//   out          out        out_valid/ready    out_data_o (found, starts, overflow)
//
// One text byte per cycle while no end byte waits; an end byte's result is registered.
// The rate is set by the single compare stage between the input and result registers.
// An end byte waits in the input register while the result register is full and not taken.
// Reset clears configuration, position and match state at once; no clearing pass.
`timescale 1ns / 1ps

module substring_first_last_match #(
  parameter int MAX_PATTERN = sflm_pkg::MaxPatternDef,
  parameter int MAX_TEXT    = sflm_pkg::MaxTextDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sflm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sflm_pkg::RegW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sflm_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sflm_pkg::out_t                out_data_o
);
  import sflm_pkg::*;

  localparam int PosW   = $clog2(MAX_TEXT + 1);
  localparam int StartW = $clog2(MAX_TEXT);

  cfg_t     cfg;
  win_ctl_t win_ctl;
  logic     hit;

  logic s1_valid_q, s1_valid_d;
  in_t  s1_data_q;
  logic adv;

  logic [PosW-1:0]   pos_q, pos_n, pos_inc, len_ext;
  logic [StartW-1:0] first_q, first_n, last_q, last_n, start;
  logic              any_q, any_n, ovf_q, ovf_n, ovf_now;

  logic out_valid_q, out_valid_d;
  out_t out_q;

  sflm_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  sflm_window #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window (
    .clk_i,
    .rst_ni,
    .cfg_i (cfg),
    .ctl_i (win_ctl),
    .hit_o (hit)
  );

  // a non-end byte always advances; an end byte needs room in the result register
  assign adv        = s1_valid_q && (!s1_data_q.text_end || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  assign ovf_now = pos_q >= PosW'(MAX_TEXT);
  assign pos_inc = pos_q + PosW'(1);
  assign len_ext = PosW'(cfg.length);
  assign start   = StartW'(pos_inc - len_ext);

  assign win_ctl.shift = adv && !ovf_now;
  assign win_ctl.data  = s1_data_q.text_byte;

  always_comb begin
    pos_n   = pos_q;
    any_n   = any_q;
    first_n = first_q;
    last_n  = last_q;
    ovf_n   = ovf_q;
    if (ovf_now) begin
      ovf_n = 1'b1;
    end else begin
      pos_n = pos_inc;
      if (hit && (pos_inc >= len_ext)) begin
        if (!any_q) begin
          first_n = start;
        end
        last_n = start;
        any_n  = 1'b1;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv && s1_data_q.text_end) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      any_q       <= 1'b0;
      first_q     <= '0;
      last_q      <= '0;
      ovf_q       <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        if (s1_data_q.text_end) begin
          pos_q   <= '0;
          any_q   <= 1'b0;
          first_q <= '0;
          last_q  <= '0;
          ovf_q   <= 1'b0;
        end else begin
          pos_q   <= pos_n;
          any_q   <= any_n;
          first_q <= first_n;
          last_q  <= last_n;
          ovf_q   <= ovf_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (adv && s1_data_q.text_end) begin
      out_q.found           <= any_n;
      out_q.first_start     <= 16'(first_n);
      out_q.last_start      <= 16'(last_n);
      out_q.length_overflow <= ovf_n;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/sflm_cfg.sv
// Configuration registers: pattern bytes and pattern length.
// Depends on sflm_pkg.
`timescale 1ns / 1ps

module sflm_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sflm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sflm_pkg::RegW-1:0]      cfg_wdata_i,
  output sflm_pkg::cfg_t                 cfg_o
);
  import sflm_pkg::*;

  logic [RegW-1:0] pat_lo_q, pat_lo_d;
  logic [RegW-1:0] pat_hi_q, pat_hi_d;
  logic [LenW-1:0] len_q, len_d;

  always_comb begin
    pat_lo_d = pat_lo_q;
    pat_hi_d = pat_hi_q;
    len_d    = len_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPatLo:  pat_lo_d = cfg_wdata_i;
        CfgPatHi:  pat_hi_d = cfg_wdata_i;
        CfgPatLen: len_d    = cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= '0;
    end else begin
      pat_lo_q <= pat_lo_d;
      pat_hi_q <= pat_hi_d;
      len_q    <= len_d;
    end
  end

  assign cfg_o.pattern = {pat_hi_q, pat_lo_q};
  assign cfg_o.length  = len_q;

endmodule

>>> hw/rtl/sflm_window.sv
// Byte window shift register and parallel compare against the pattern.
// Depends on sflm_pkg.
`timescale 1ns / 1ps

module sflm_window #(
  parameter int MAX_PATTERN = sflm_pkg::MaxPatternDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sflm_pkg::cfg_t      cfg_i,
  input  sflm_pkg::win_ctl_t  ctl_i,
  output logic                hit_o
);
  import sflm_pkg::*;

  localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [MAX_PATTERN-1:0][7:0] win_q;
  logic [MAX_PATTERN-1:0][7:0] win_n;
  logic [MAX_PATTERN-1:0]      ok;
  logic [LenW-1:0]             diff [MAX_PATTERN];
  logic                        len_ok;

  // entry 0 is the newest byte
  always_comb begin
    win_n[0] = ctl_i.data;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_n[i] = win_q[i-1];
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      diff[k] = cfg_i.length - LenW'(k + 1);
      ok[k]   = (LenW'(k) >= cfg_i.length) ||
                (win_n[diff[k][IdxW-1:0]] == cfg_i.pattern[k]);
    end
  end

  assign len_ok = (cfg_i.length != '0) && (cfg_i.length <= LenW'(MAX_PATTERN));
  assign hit_o  = len_ok && (&ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctl_i.shift) begin
      win_q <= win_n;
    end
  end

endmodule

>>> hw/rtl/sflm_checker.sv
// Port-level checks on the result channel of the match block, and its bind.
// Depends on sflm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sflm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input sflm_pkg::out_t out_data_o
);
  import sflm_pkg::*;

  logic stalled;
  logic miss_nonzero;
  logic order_bad;

  assign stalled      = out_valid_o && !out_ready_i;
  assign miss_nonzero = !out_data_o.found &&
                        (out_data_o.first_start != 16'd0 || out_data_o.last_start != 16'd0);
  assign order_bad    = out_data_o.found && (out_data_o.first_start > out_data_o.last_start);

  `ASSERT_CLK(a_out_hold, stalled |=> out_valid_o && $stable(out_data_o), "result not held")
  `ASSERT_NEVER(a_miss_zero, out_valid_o && miss_nonzero, "start index set without a match")
  `ASSERT_NEVER(a_order, out_valid_o && order_bad, "first occurrence after last occurrence")

endmodule

bind substring_first_last_match sflm_checker u_sflm_checker (.*);

>>> verif/sflm_match_checker.sv
// Checker for substring_first_last_match: watches config writes and both channels,
// tracks the text window and occurrences, and compares every result transfer.
// Depends on sflm_pkg.
`timescale 1ns / 1ps

module sflm_match_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sflm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sflm_pkg::RegW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  sflm_pkg::in_t                in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  sflm_pkg::out_t               out_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import sflm_pkg::*;

  cfg_t        pat_cfg;
  logic [7:0]  win [PatBytes];
  int unsigned text_pos;
  logic        hit_any;
  logic [15:0] hit_first;
  logic [15:0] hit_last;
  logic        text_ovf;
  out_t        match_q [$];
  int          fails;

  task automatic clear_text();
    for (int k = 0; k < PatBytes; k++) win[k] = 8'h00;
    text_pos  = 0;
    hit_any   = 1'b0;
    hit_first = '0;
    hit_last  = '0;
    text_ovf  = 1'b0;
  endtask

  task automatic take_text_byte(input in_t item);
    out_t        res;
    int unsigned len;
    logic        hit;
    len = pat_cfg.length;
    if (text_pos >= MaxTextDef) begin
      text_ovf = 1'b1;
    end else begin
      for (int k = PatBytes - 1; k > 0; k--) win[k] = win[k-1];
      win[0] = item.text_byte;
      text_pos++;
      if (len >= 1 && len <= MaxPatternDef && text_pos >= len) begin
        hit = 1'b1;
        for (int k = 0; k < len; k++) begin
          if (win[len-1-k] != pat_cfg.pattern[k]) hit = 1'b0;
        end
        if (hit) begin
          if (!hit_any) hit_first = 16'(text_pos - len);
          hit_last = 16'(text_pos - len);
          hit_any  = 1'b1;
        end
      end
    end
    if (item.text_end) begin
      res.found           = hit_any;
      res.first_start     = hit_any ? hit_first : '0;
      res.last_start      = hit_any ? hit_last : '0;
      res.length_overflow = text_ovf;
      match_q.push_back(res);
      clear_text();
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] expv,
                             input logic [15:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0h, actual %0h", name, expv, actv);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      pat_cfg = '0;
      clear_text();
      match_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPatLo:  pat_cfg.pattern[7:0]  = cfg_wdata_i;
          CfgPatHi:  pat_cfg.pattern[15:8] = cfg_wdata_i;
          CfgPatLen: pat_cfg.length        = cfg_wdata_i[LenW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (match_q.size() == 0) begin
          $error("result transfer with nothing expected: %0h", out_data_i);
          fails++;
        end else begin
          want = match_q.pop_front();
          check_field("found", 16'(want.found), 16'(out_data_i.found));
          check_field("first_start", want.first_start, out_data_i.first_start);
          check_field("last_start", want.last_start, out_data_i.last_start);
          check_field("length_overflow", 16'(want.length_overflow),
                      16'(out_data_i.length_overflow));
        end
      end
      if (in_valid_i && in_ready_i) take_text_byte(in_data_i);
    end
    fail_count_o <= fails;
    pending_o    <= match_q.size();
  end

endmodule

>>> verif/substring_first_last_match_tb.sv
// Testbench top for substring_first_last_match: drives pattern setups and texts
// with random gaps and stalls; sflm_match_checker predicts and compares results.
// Depends on sflm_pkg, sflm_match_checker and the block itself.
`timescale 1ns / 1ps

module substring_first_last_match_tb;
  import sflm_pkg::*;

  localparam int QuietLimit = 1000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = '0;
  logic [RegW-1:0]    cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_t                in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_t               out_data;
  int                 fail_count;
  int                 pending;

  bit         idle_en    = 1'b1;
  bit         full_range = 1'b0;
  logic [7:0] alpha [3];
  logic [7:0] pat [PatBytes];
  int         cur_len;
  int         quiet;

  always #4 clk = ~clk;

  substring_first_last_match dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  sflm_match_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side back-pressure
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (idle_en && $urandom_range(3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(18, 1)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(30, 1)) @(posedge clk);
    end
  end

  function automatic logic [7:0] pick_byte();
    return full_range ? 8'($urandom) : alpha[$urandom_range(2)];
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic e);
    in_valid <= 1'b1;
    in_data  <= '{text_byte: b, text_end: e};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (idle_en && $urandom_range(5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
  endtask

  // stop sending and wait until every result is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len);
    logic [63:0] w;
    settle();
    w      = {$urandom, $urandom};
    w[4:0] = len;
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgPatLo;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_idx   <= CfgPatHi;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_idx   <= CfgPatLen;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    for (int k = 0; k < 8; k++) begin
      pat[k]   = lo[8*k +: 8];
      pat[k+8] = hi[8*k +: 8];
    end
    cur_len = len;
  endtask

  task automatic send_text(input int n, input bit planted);
    logic [7:0] txt [$];
    int         at;
    int         plen;
    plen = (cur_len >= 1 && cur_len <= MaxPatternDef) ? cur_len : 0;
    for (int i = 0; i < n; i++) txt.push_back(pick_byte());
    if (planted && plen > 0 && plen <= n) begin
      repeat ($urandom_range(3, 1)) begin
        at = $urandom_range(n - plen);
        for (int k = 0; k < plen; k++) txt[at+k] = pat[k];
      end
    end
    for (int i = 0; i < n; i++) put_byte(txt[i], i == n - 1);
  endtask

  // text of background bytes with the repeated byte a from match_from on
  task automatic send_run(input int n, input int match_from, input logic [7:0] a,
                          input logic [7:0] bg);
    for (int i = 0; i < n; i++) put_byte((i >= match_from) ? a : bg, i == n - 1);
  endtask

  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic [7:0]  a;
    int          n;
    int          sent;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // directed: reset config (empty pattern), zero bytes, full-length pattern,
    // pattern longer than the text, oversized length
    cur_len = 0;
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b1);
    load_pattern('0, '0, 5'd2);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b1);
    load_pattern(64'hFF00_5AA5_C33C_0FF0, 64'h00FF_A55A_3CC3_F00F, 5'd16);
    for (int k = 0; k < PatBytes; k++) put_byte(pat[k], k == PatBytes - 1);
    for (int k = 0; k < 3; k++) put_byte(pat[k], k == 2);
    load_pattern(64'hFF00_5AA5_C33C_0FF0, 64'h00FF_A55A_3CC3_F00F, 5'd17);
    put_byte(pat[0], 1'b0);
    put_byte(pat[1], 1'b1);

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      idle_en    = (ph % 3 != 2);
      full_range = ($urandom_range(3) == 0);
      for (int i = 0; i < 3; i++) alpha[i] = 8'($urandom);
      for (int k = 0; k < 8; k++) begin
        lo[8*k +: 8] = pick_byte();
        hi[8*k +: 8] = pick_byte();
      end
      case (ph)
        0:       len = 5'd16;
        1:       len = 5'd0;
        2:       len = 5'd31;
        3:       len = 5'($urandom_range(31, 17));
        default: len = ($urandom_range(3) == 0) ? 5'($urandom_range(16, 7))
                                                : 5'($urandom_range(6, 1));
      endcase
      load_pattern(lo, hi, len);
      sent = 0;
      while (sent < 30) begin
        if (ph == 5 && sent > 20 && sent < 30) settle();
        n = ($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
        send_text(n, $urandom_range(4) != 0);
        sent += n;
      end
    end

    // last part without idling: overlapping runs of a repeated byte
    idle_en = 1'b0;
    a = 8'($urandom);
    load_pattern({$urandom, 16'($urandom), a, a}, {$urandom, $urandom}, 5'd2);
    send_run(30, 26, a, a ^ 8'($urandom_range(255, 1)));
    send_run(20, 0, a, a ^ 8'($urandom_range(255, 1)));

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
